@@ rtl/mprt_pkg.sv @@
// Package for the message part reassembly table.
// Holds operation and status codes, slot entry type and the controller/datapath
// command and status structs; used by every module of the block.
package mprt_pkg;

  // Width and limits of item fields
  localparam int unsigned MaxPartLen = 160;
  localparam int unsigned PartCodes  = 256;

  typedef enum logic [1:0] {
    FN_PART  = 2'd0,
    FN_ASM   = 2'd1,
    FN_DEL   = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_OK   = 2'd3
  } status_e;

  // Kind of work done on each entry during a table scan
  typedef enum logic [2:0] {
    PS_FREE,
    PS_EVICT,
    PS_CHECK,
    PS_ASM,
    PS_DEL,
    PS_CLEAR
  } pass_e;

  // Kind of result item to build in the output register
  typedef enum logic [2:0] {
    EM_NONE,
    EM_ARR_ERR,
    EM_ARR_OK,
    EM_ASM_EMPTY,
    EM_ASM_ZERO,
    EM_ASM_PART,
    EM_ASM_MISS,
    EM_ACK
  } emit_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_EVICT,
    S_LENCHK,
    S_WRITE,
    S_CHECK,
    S_ASM,
    S_ASM_DEC,
    S_ASM_RD,
    S_ASM_OUT,
    S_DEL,
    S_CLEAR
  } state_e;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] part;
    logic [7:0] total;
    logic [7:0] len;
    logic       valid;
  } slot_t;

  typedef struct packed {
    logic  load;
    logic  pass_start;
    logic  pass_run;
    pass_e mode;
    logic  write_new;
    logic  p_init;
    logic  p_next;
    logic  asm_rd;
    emit_e emit;
  } dp_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic found;
    logic len_bad;
    logic sum_zero;
    logic num_zero;
    logic present;
    logic p_last;
  } dp_sts_t;

endpackage

@@ rtl/message_part_reassembly_table.sv @@
// Top level of the message part reassembly table.
// Joins the controller mprt_ctrl and the datapath mprt_dp; depends on mprt_pkg.
//
// Usage: raise start_i with the item fields while busy_o is low. Results come
// out one per cycle-long valid_o strobe and cannot be held off; last_o marks
// the final one of an item. Every operation scans the slot table one slot per
// cycle through the single read port of the slot memory. A part arrival runs
// a free-slot scan, an evict scan if no slot is free, then a length check that
// either ends it or leads to the write and a check scan; assemble runs one
// scan, then reads and emits each listed part; delete and clear run one scan.
module message_part_reassembly_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  msg_id_i,
  input  logic [7:0]  part_number_i,
  input  logic [7:0]  total_parts_i,
  input  logic [9:0]  part_length_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_index_o,
  output logic [7:0]  slot_length_o,
  output logic [13:0] message_length_o,
  output logic        last_o
);
  import mprt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the operations
  mprt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Hold the table and build results
  mprt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .msg_id_i         (msg_id_i),
    .part_number_i    (part_number_i),
    .total_parts_i    (total_parts_i),
    .part_length_i    (part_length_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .slot_length_o    (slot_length_o),
    .message_length_o (message_length_o),
    .last_o           (last_o)
  );

endmodule

@@ rtl/mprt_ctrl.sv @@
// Controller state machine of the message part reassembly table.
// Sequences table scans and result items; depends on mprt_pkg.
module mprt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        func_i,
  input  mprt_pkg::dp_sts_t sts_i,
  output mprt_pkg::dp_cmd_t cmd_o,
  output logic              busy_o
);
  import mprt_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (func_e'(func_i))
            FN_PART:  state_d = S_FREE;
            FN_ASM:   state_d = S_ASM;
            FN_DEL:   state_d = S_DEL;
            FN_CLEAR: state_d = S_CLEAR;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_FREE: begin
        if (sts_i.pass_done) begin
          state_d = sts_i.found ? S_LENCHK : S_EVICT;
        end
      end
      S_EVICT: begin
        if (sts_i.pass_done) state_d = S_LENCHK;
      end
      S_LENCHK: begin
        state_d = (!sts_i.found || sts_i.len_bad) ? S_IDLE : S_WRITE;
      end
      S_WRITE: state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.pass_done) state_d = S_IDLE;
      end
      S_ASM: begin
        if (sts_i.pass_done) state_d = S_ASM_DEC;
      end
      S_ASM_DEC: begin
        state_d = (sts_i.sum_zero || sts_i.num_zero) ? S_IDLE : S_ASM_RD;
      end
      S_ASM_RD: state_d = S_ASM_OUT;
      S_ASM_OUT: begin
        state_d = (!sts_i.present || sts_i.p_last) ? S_IDLE : S_ASM_RD;
      end
      S_DEL, S_CLEAR: begin
        if (sts_i.pass_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o            = '0;
    cmd_o.mode       = PS_FREE;
    cmd_o.emit       = EM_NONE;
    cmd_o.load       = (state_q == S_IDLE) && start_i;
    cmd_o.pass_start = (state_d != state_q) &&
                       ((state_d == S_FREE) || (state_d == S_EVICT) ||
                        (state_d == S_CHECK) || (state_d == S_ASM) ||
                        (state_d == S_DEL) || (state_d == S_CLEAR));
    unique case (state_q)
      S_FREE: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.mode     = PS_FREE;
      end
      S_EVICT: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.mode     = PS_EVICT;
      end
      S_LENCHK: begin
        if (!sts_i.found || sts_i.len_bad) cmd_o.emit = EM_ARR_ERR;
      end
      S_WRITE: cmd_o.write_new = 1'b1;
      S_CHECK: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.mode     = PS_CHECK;
        if (sts_i.pass_done) cmd_o.emit = EM_ARR_OK;
      end
      S_ASM: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.mode     = PS_ASM;
      end
      S_ASM_DEC: begin
        cmd_o.p_init = 1'b1;
        if (sts_i.sum_zero) begin
          cmd_o.emit = EM_ASM_EMPTY;
        end else if (sts_i.num_zero) begin
          cmd_o.emit = EM_ASM_ZERO;
        end
      end
      S_ASM_RD: cmd_o.asm_rd = 1'b1;
      S_ASM_OUT: begin
        cmd_o.p_next = 1'b1;
        cmd_o.emit   = sts_i.present ? EM_ASM_PART : EM_ASM_MISS;
      end
      S_DEL: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.mode     = PS_DEL;
        if (sts_i.pass_done) cmd_o.emit = EM_ACK;
      end
      S_CLEAR: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.mode     = PS_CLEAR;
        if (sts_i.pass_done) cmd_o.emit = EM_ACK;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ rtl/mprt_dp.sv @@
// Datapath of the message part reassembly table: slot memory, scan pipeline,
// part map and output register. Depends on mprt_pkg; driven by mprt_ctrl.
module mprt_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mprt_pkg::dp_cmd_t cmd_i,
  output mprt_pkg::dp_sts_t sts_o,
  input  logic [7:0]        msg_id_i,
  input  logic [7:0]        part_number_i,
  input  logic [7:0]        total_parts_i,
  input  logic [9:0]        part_length_i,
  output logic              valid_o,
  output logic [1:0]        status_o,
  output logic [5:0]        slot_index_o,
  output logic [7:0]        slot_length_o,
  output logic [13:0]       message_length_o,
  output logic              last_o
);
  import mprt_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Latched operands
  logic [7:0] id_q, part_q, total_q;
  logic [9:0] plen_q;

  // Slot memory and written marks
  slot_t          mem_q [SLOTS];
  logic [SLOTS-1:0] wr_q;
  slot_t          rd_q;
  logic           rok_q;
  slot_t          ent;

  // Scan pipeline
  logic [CW-1:0] cnt_q;
  logic          pv_q;
  logic [AW-1:0] pidx_q;
  logic          rd_en;

  // Search and summary results
  logic          found_q;
  logic          free_hit;
  logic [AW-1:0] sidx_q;
  logic [7:0]    dcnt_q;
  logic [13:0]   sum_q;
  logic [7:0]    num_q;
  logic [7:0]    p_q;

  // Part map: presence bits and slot/length per part number
  logic [PartCodes-1:0] pbit_q;
  logic [13:0]          pmap_q [PartCodes];
  logic [13:0]          mrd_q;
  logic                 pres_q;

  // Write port
  logic          we;
  logic [AW-1:0] waddr;
  slot_t         wdata;
  logic          map_we;
  logic          hit_id, new_part;

  assign ent      = rok_q ? rd_q : '0;
  assign rd_en    = cmd_i.pass_run && (cnt_q < CW'(SLOTS));
  assign hit_id   = (ent.id == id_q);
  assign new_part = ent.valid && hit_id && (ent.part != 8'd0) && !pbit_q[ent.part];
  // Free entry seen on the current scan cycle
  assign free_hit = cmd_i.pass_run && pv_q && (cmd_i.mode == PS_FREE) && (ent.len == 8'd0);

  // Per-entry scan work
  always_comb begin
    we     = 1'b0;
    waddr  = pidx_q;
    wdata  = '{id: ent.id, part: ent.part, total: ent.total, len: 8'd0, valid: 1'b0};
    map_we = 1'b0;
    if (cmd_i.write_new) begin
      we    = 1'b1;
      waddr = sidx_q;
      wdata = '{id: id_q, part: part_q, total: total_q, len: plen_q[7:0], valid: 1'b1};
    end else if (cmd_i.pass_run && pv_q) begin
      unique case (cmd_i.mode)
        PS_EVICT: we = !hit_id;
        PS_DEL: begin
          we    = hit_id;
          wdata = '{id: 8'd0, part: 8'd0, total: ent.total, len: 8'd0, valid: 1'b0};
        end
        PS_CLEAR: we = 1'b1;
        PS_CHECK: map_we = new_part && (ent.part <= total_q);
        PS_ASM:   map_we = new_part;
        default: ;
      endcase
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd_en) rd_q <= mem_q[cnt_q[AW-1:0]];
    if (map_we && (cmd_i.mode == PS_ASM)) pmap_q[ent.part] <= {6'(pidx_q), ent.len};
    if (cmd_i.asm_rd) mrd_q <= pmap_q[p_q];
  end

  // Control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rok_q   <= 1'b0;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      pidx_q  <= '0;
      found_q <= 1'b0;
      sidx_q  <= '0;
      dcnt_q  <= '0;
      sum_q   <= '0;
      num_q   <= '0;
      p_q     <= '0;
      pbit_q  <= '0;
      pres_q  <= 1'b0;
    end else begin
      if (we) wr_q[waddr] <= 1'b1;
      if (cmd_i.load) begin
        found_q <= 1'b0;
        dcnt_q  <= '0;
        sum_q   <= '0;
        num_q   <= '0;
        pbit_q  <= '0;
      end
      // Advance the scan
      if (cmd_i.pass_start) begin
        cnt_q <= '0;
        pv_q  <= 1'b0;
      end else if (cmd_i.pass_run) begin
        pv_q   <= rd_en;
        pidx_q <= cnt_q[AW-1:0];
        if (rd_en) begin
          cnt_q <= cnt_q + 1'b1;
          rok_q <= wr_q[cnt_q[AW-1:0]];
        end
      end
      if (map_we) begin
        pbit_q[ent.part] <= 1'b1;
        dcnt_q           <= dcnt_q + 8'd1;
      end
      // Collect scan results
      if (cmd_i.pass_run && pv_q) begin
        unique case (cmd_i.mode)
          PS_FREE: begin
            if (!found_q && (ent.len == 8'd0)) begin
              found_q <= 1'b1;
              sidx_q  <= pidx_q;
            end
          end
          PS_EVICT: begin
            if (!found_q && !hit_id) begin
              found_q <= 1'b1;
              sidx_q  <= pidx_q;
            end
          end
          PS_ASM: begin
            if ((ent.len != 8'd0) && hit_id) begin
              sum_q <= sum_q + 14'(ent.len);
              num_q <= ent.total;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.p_init) p_q <= 8'd1;
      else if (cmd_i.p_next) p_q <= p_q + 8'd1;
      if (cmd_i.asm_rd) pres_q <= pbit_q[p_q];
    end
  end

  // Hold operands of the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q    <= msg_id_i;
      part_q  <= part_number_i;
      total_q <= total_parts_i;
      plen_q  <= part_length_i;
    end
  end

  assign sts_o.pass_done = cmd_i.pass_run && pv_q && (pidx_q == AW'(SLOTS - 1));
  assign sts_o.found     = found_q || free_hit;
  assign sts_o.len_bad   = (plen_q > 10'(MaxPartLen));
  assign sts_o.sum_zero  = (sum_q == 14'd0);
  assign sts_o.num_zero  = (num_q == 8'd0);
  assign sts_o.present   = pres_q;
  assign sts_o.p_last    = (p_q == num_q);

  // Output register
  logic        val_q;
  logic [1:0]  st_q;
  logic [5:0]  idx_q;
  logic [7:0]  slen_q;
  logic [13:0] mlen_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
    end else begin
      val_q <= (cmd_i.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EM_NONE) begin
      st_q   <= ST_ERR;
      idx_q  <= '0;
      slen_q <= '0;
      mlen_q <= '0;
      last_q <= 1'b1;
      unique case (cmd_i.emit)
        EM_ARR_OK: begin
          // Count the last scanned entry too
          st_q   <= ((dcnt_q + 8'(map_we)) == total_q) ? ST_DONE : ST_WAIT;
          idx_q  <= 6'(sidx_q);
          slen_q <= plen_q[7:0];
        end
        EM_ASM_ZERO: begin
          st_q   <= ST_OK;
          mlen_q <= sum_q;
        end
        EM_ASM_PART: begin
          st_q   <= ST_OK;
          idx_q  <= mrd_q[13:8];
          slen_q <= mrd_q[7:0];
          mlen_q <= sum_q;
          last_q <= (p_q == num_q);
        end
        EM_ASM_MISS: mlen_q <= sum_q;
        EM_ACK:      st_q   <= ST_OK;
        default: ;
      endcase
    end
  end

  assign valid_o          = val_q;
  assign status_o         = st_q;
  assign slot_index_o     = idx_q;
  assign slot_length_o    = slen_q;
  assign message_length_o = mlen_q;
  assign last_o           = last_q;

endmodule
